// ===== sv/pidf_pkg.sv =====
// ----------------------------------------------------------------------------
// pidf_pkg: shared types and constants of the PNG IDAT stored-zlib framer
// Holds the queue item formats, the back-end phase encoding and the fixed
// values of the chunk and zlib framing.
// ----------------------------------------------------------------------------
package pidf_pkg;

    localparam int unsigned RAW_W       = 24;
    localparam int unsigned BLK_W       = 16;
    localparam int unsigned FRONT_DEPTH = 4;
    localparam int unsigned OUT_DEPTH   = 4;

    localparam logic [RAW_W-1:0] RAW_LEN_RESET   = 24'd1;
    localparam logic [31:0]      CHUNK_LEN_RESET = 32'd12;
    localparam logic [BLK_W-1:0] BLOCK_MAX       = 16'hFFFF;
    localparam logic [16:0]      ADLER_MOD       = 17'd65521;
    localparam logic [31:0]      CRC_POLY        = 32'hEDB88320;
    localparam logic [31:0]      ALL_ONES        = 32'hFFFFFFFF;
    localparam logic [31:0]      CHUNK_TYPE      = 32'h49444154;
    localparam logic [7:0]       ZLIB_CMF        = 8'h78;
    localparam logic [7:0]       ZLIB_FLG        = 8'h01;

    // One classified raw byte, handed from the front end to the back end.
    typedef struct packed {
        logic [7:0]       data;
        logic             first;
        logic             hdr;
        logic             final_blk;
        logic             last;
        logic [BLK_W-1:0] blk_len;
        logic [31:0]      chunk_len;
    } t_item;

    // One output beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       chunk_end;
    } t_beat;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_HDR,
        PH_DATA,
        PH_ADLER,
        PH_CRC
    } t_phase;

endpackage

// ===== sv/png_idat_stored_zlib_framer_unit.sv =====
// A raw byte reaches the output through the item queue, the back end's current
// item register and the output queue. Throughput: one output beat per cycle
// from the back-end sequencer while the output queue has room; a plain data byte
// gives one beat, a chunk's first byte 16, a block's first byte 6, and a chunk's last byte 9.
// Reset clears all queues and chunk state and sets the raw length to one.
// ----------------------------------------------------------------------------
// png_idat_stored_zlib_framer_unit: PNG IDAT chunk framer, stored deflate
// Wraps a stream of raw scanline bytes in an IDAT chunk holding a zlib stream
// of stored blocks, with Adler-32 and CRC-32 trailers.
// ----------------------------------------------------------------------------
module png_idat_stored_zlib_framer_unit #(
    parameter int unsigned FRONT_QDEPTH = pidf_pkg::FRONT_DEPTH,
    parameter int unsigned OUT_QDEPTH   = pidf_pkg::OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_chunk_end
);

    import pidf_pkg::*;

    t_item item_in, item_out;
    t_beat beat_in, beat_out;
    logic  accept, item_empty, item_pop, out_full, emit;

    assign accept = push && !full;

    pidf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_item      (item_in)
    );

    pidf_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (FRONT_QDEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (item_in),
        .o_full  (full),
        .i_rd    (item_pop),
        .o_rdata (item_out),
        .o_empty (item_empty)
    );

    pidf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_out),
        .i_item_valid (!item_empty),
        .o_item_pop   (item_pop),
        .i_space      (!out_full),
        .o_emit       (emit),
        .o_beat       (beat_in)
    );

    pidf_queue #(
        .WIDTH ($bits(t_beat)),
        .DEPTH (OUT_QDEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (emit),
        .i_wdata (beat_in),
        .o_full  (out_full),
        .i_rd    (pop),
        .o_rdata (beat_out),
        .o_empty (empty)
    );

    assign o_out_byte  = beat_out.out_byte;
    assign o_run_last  = beat_out.run_last;
    assign o_chunk_end = beat_out.chunk_end;

endmodule

// ===== sv/pidf_queue.sv =====
// ----------------------------------------------------------------------------
// pidf_queue: small first-in first-out queue
// Register-based queue with a fill count; the head entry is shown while the
// queue is not empty.
// ----------------------------------------------------------------------------
module pidf_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/pidf_front.sv =====
// ----------------------------------------------------------------------------
// pidf_front: byte classifier of the framer
// Holds the raw length register and the chunk and block position, and tags
// each accepted raw byte with what has to be emitted around it.
// ----------------------------------------------------------------------------
module pidf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [23:0]            i_cfg_wdata,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    output pidf_pkg::t_item        o_item
);

    import pidf_pkg::*;

    logic [RAW_W-1:0] r_raw_length;
    logic [31:0]      r_chunk_len;
    logic [RAW_W-1:0] r_chunk_raw;
    logic [RAW_W-1:0] r_bytes_seen;
    logic [BLK_W-1:0] r_block_left;

    logic             first, hdr, fits, last;
    logic [RAW_W-1:0] craw, rem, cfg_raw;
    logic [BLK_W-1:0] blen;
    logic [RAW_W:0]   seen_n;

    // Chunk length = raw + 6 + 5 * ceil(raw / 65535). The quotient by 65535
    // starts from raw >> 16 and is fixed up with one compare and subtract.
    function automatic logic [31:0] chunk_length(input logic [RAW_W-1:0] x);
        logic [16:0] r0;
        logic        ge;
        logic [8:0]  q;
        logic [16:0] r;
        logic [8:0]  b;
        logic [10:0] b5;
        r0 = {1'b0, x[15:0]} + 17'(x[23:16]);
        ge = (r0 >= 17'(BLOCK_MAX));
        q  = 9'(x[23:16]) + 9'(ge);
        r  = ge ? r0 - 17'(BLOCK_MAX) : r0;
        b  = q + 9'(r != '0);
        b5 = {b, 2'b00} + 11'(b);
        return 32'(x) + 32'd6 + 32'(b5);
    endfunction

    assign cfg_raw = (i_cfg_wdata == '0) ? RAW_LEN_RESET : i_cfg_wdata;

    always_comb begin
        first  = (r_bytes_seen == '0);
        craw   = first ? r_raw_length : r_chunk_raw;
        rem    = craw - r_bytes_seen;
        fits   = (rem <= RAW_W'(BLOCK_MAX));
        blen   = fits ? rem[BLK_W-1:0] : BLOCK_MAX;
        hdr    = (r_block_left == '0);
        seen_n = {1'b0, r_bytes_seen} + 1'b1;
        last   = (seen_n >= {1'b0, craw});

        o_item.data      = i_data_byte;
        o_item.first     = first;
        o_item.hdr       = hdr;
        o_item.final_blk = fits;
        o_item.last      = last;
        o_item.blk_len   = blen;
        o_item.chunk_len = r_chunk_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_length <= RAW_LEN_RESET;
            r_chunk_len  <= CHUNK_LEN_RESET;
            r_chunk_raw  <= RAW_LEN_RESET;
            r_bytes_seen <= '0;
            r_block_left <= '0;
        end else begin
            // A new length takes effect with the next chunk opened.
            if (i_cfg_we) begin
                r_raw_length <= cfg_raw;
                r_chunk_len  <= chunk_length(cfg_raw);
            end
            if (i_accept) begin
                if (first) begin
                    r_chunk_raw <= craw;
                end
                if (last) begin
                    r_bytes_seen <= '0;
                    r_block_left <= '0;
                end else begin
                    r_bytes_seen <= seen_n[RAW_W-1:0];
                    r_block_left <= (hdr ? blen : r_block_left) - 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/pidf_back.sv =====
// ----------------------------------------------------------------------------
// pidf_back: byte sequencer of the framer
// Expands each tagged raw byte into chunk, block header, data and trailer
// beats, one beat a cycle while the output queue has room, and keeps the running CRC-32 and Adler-32.
// ----------------------------------------------------------------------------
module pidf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pidf_pkg::t_item  i_item,
    input  logic             i_item_valid,
    output logic             o_item_pop,
    input  logic             i_space,
    output logic             o_emit,
    output pidf_pkg::t_beat  o_beat
);

    import pidf_pkg::*;

    t_item       r_cur;
    logic        r_busy;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_crc;
    logic [15:0] r_adl_lo, r_adl_hi;

    logic [7:0]  byte_out;
    logic        in_crc, ph_last, end_entry, chunk_end, emit, load;
    logic [16:0] lo_sum, lo_n, hi_sum, hi_n;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Big-endian byte pick: sel 0 is the top byte.
    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
        return w[(5'd24 - {sel, 3'b000}) +: 8];
    endfunction

    // Beat contents for the current phase and position.
    always_comb begin
        byte_out = r_cur.data;
        in_crc   = 1'b1;
        ph_last  = 1'b0;
        unique case (r_phase)
            PH_OPEN: begin
                in_crc  = (r_idx >= 4'd4);
                ph_last = (r_idx == 4'd9);
                if (r_idx < 4'd4) begin
                    byte_out = be_byte(r_cur.chunk_len, r_idx[1:0]);
                end else if (r_idx < 4'd8) begin
                    byte_out = be_byte(CHUNK_TYPE, r_idx[1:0]);
                end else if (r_idx == 4'd8) begin
                    byte_out = ZLIB_CMF;
                end else begin
                    byte_out = ZLIB_FLG;
                end
            end
            PH_HDR: begin
                ph_last = (r_idx == 4'd4);
                case (r_idx)
                    4'd0:    byte_out = {7'd0, r_cur.final_blk};
                    4'd1:    byte_out = r_cur.blk_len[7:0];
                    4'd2:    byte_out = r_cur.blk_len[15:8];
                    4'd3:    byte_out = ~r_cur.blk_len[7:0];
                    default: byte_out = ~r_cur.blk_len[15:8];
                endcase
            end
            PH_DATA: begin
                ph_last  = 1'b1;
                byte_out = r_cur.data;
            end
            PH_ADLER: begin
                ph_last  = (r_idx == 4'd3);
                byte_out = be_byte({r_adl_hi, r_adl_lo}, r_idx[1:0]);
            end
            PH_CRC: begin
                in_crc   = 1'b0;
                ph_last  = (r_idx == 4'd3);
                byte_out = be_byte(~r_crc, r_idx[1:0]);
            end
            default: begin
                in_crc = 1'b0;
            end
        endcase
        chunk_end = (r_phase == PH_CRC) && ph_last;
        end_entry = ph_last && ((r_phase == PH_CRC) ||
                                ((r_phase == PH_DATA) && !r_cur.last));
    end

    assign emit = r_busy && i_space;
    assign load = i_item_valid && (!r_busy || (emit && end_entry));

    assign o_emit             = emit;
    assign o_item_pop         = load;
    assign o_beat.out_byte    = byte_out;
    assign o_beat.run_last    = end_entry;
    assign o_beat.chunk_end   = chunk_end;

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (load) begin
            n_idx = '0;
            if (i_item.first) begin
                n_phase = PH_OPEN;
            end else if (i_item.hdr) begin
                n_phase = PH_HDR;
            end else begin
                n_phase = PH_DATA;
            end
        end else if (emit) begin
            if (!ph_last) begin
                n_idx = r_idx + 1'b1;
            end else begin
                n_idx = '0;
                unique case (r_phase)
                    PH_OPEN:  n_phase = PH_HDR;
                    PH_HDR:   n_phase = PH_DATA;
                    PH_DATA:  n_phase = PH_ADLER;
                    PH_ADLER: n_phase = PH_CRC;
                    PH_CRC:   n_phase = PH_CRC;
                    default:  n_phase = PH_DATA;
                endcase
            end
        end
    end

    // Adler-32 step: both sums stay below twice the modulus.
    always_comb begin
        lo_sum = {1'b0, r_adl_lo} + 17'(r_cur.data);
        lo_n   = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
        hi_sum = {1'b0, r_adl_hi} + lo_n;
        hi_n   = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_DATA;
            r_idx    <= '0;
            r_crc    <= ALL_ONES;
            r_adl_lo <= 16'd1;
            r_adl_hi <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && end_entry) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                if (chunk_end) begin
                    r_crc    <= ALL_ONES;
                    r_adl_lo <= 16'd1;
                    r_adl_hi <= '0;
                end else begin
                    if (in_crc) begin
                        r_crc <= crc_byte(r_crc, byte_out);
                    end
                    if (r_phase == PH_DATA) begin
                        r_adl_lo <= lo_n[15:0];
                        r_adl_hi <= hi_n[15:0];
                    end
                end
            end
        end
    end

endmodule
